>>> hw/rtl/pol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_pkg
// shared widths, codes and the control bundle broadcast along the cell row
// ----------------------------------------------------------------------------
package pol_pkg;

    localparam int DATA_W        = 32;
    localparam int POS_W         = 8;
    localparam int CMD_W         = 2;
    localparam int STAT_W        = 2;
    localparam int ECNT_W        = 8;
    localparam int S_TDATA_W     = 48;
    localparam int M_TDATA_W     = 48;
    localparam int DEPTH_DEFAULT = 128;
    localparam int GROUP_SIZE    = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  target;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/positional_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_ordered_list
// ordered list of signed words addressed by 1-based position, kept in a row
// of shifting cells; insert, delete and read by position
//
// channel  dir  tdata fields (low bit up)
// s_*      in   cmd[1:0] position[9:2] value[41:10]
// m_*      out  read_value[31:0] entry_count[39:32] status[41:40]
//
// one beat in flight: accept, then check and shift the cells while
// the selected entry enters the or-tree, then register the result
// next input only after the result beat is taken
// a stalled result holds s_tready low
// reset clears count and handshake state; entries hold no reset value
// ----------------------------------------------------------------------------
module positional_ordered_list #(
    parameter int DEPTH = pol_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pol_pkg::S_TDATA_W-1:0] s_tdata,  // cmd, position, value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pol_pkg::M_TDATA_W-1:0] m_tdata   // read_value, entry_count, status
);
    import pol_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = CNT_W + POS_W;

    logic [CMD_W-1:0]  cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] value_reg;
    logic              s1_reg;
    logic              s2_reg;
    logic              out_valid_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic              keep_reg;
    logic              keep_next;
    logic [DATA_W-1:0] rdata_reg;
    logic [ECNT_W-1:0] ecnt_reg;
    logic [STAT_W-1:0] ostat_reg;

    logic [EXT_W-1:0]  cnt_ext;
    logic [EXT_W-1:0]  pos_ext;
    logic              in_beat;
    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] entry [DEPTH];
    logic [DATA_W-1:0] taps  [DEPTH];
    logic [DATA_W-1:0] gathered;

    assign in_beat  = s_tvalid && s_tready;
    assign s_tready = !(s1_reg || s2_reg || out_valid_reg);
    assign cnt_ext  = EXT_W'(count_reg);
    assign pos_ext  = EXT_W'(pos_reg);

    always_comb
    begin
        ctrl        = '0;
        ctrl.target = pos_reg - POS_W'(1);
        ctrl.value  = value_reg;
        count_next  = count_reg;
        status_next = STAT_RANGE;
        keep_next   = 1'b0;
        case (cmd_reg)
            CMD_INSERT:
            begin
                if (count_reg >= CNT_W'(DEPTH))
                begin
                    status_next = STAT_FULL;
                end
                else if (pos_reg != '0 && pos_ext <= cnt_ext + EXT_W'(1))
                begin
                    status_next = STAT_OK;
                    ctrl.ins    = s1_reg;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            CMD_DELETE:
            begin
                if (pos_reg != '0 && pos_ext <= cnt_ext)
                begin
                    status_next = STAT_OK;
                    keep_next   = 1'b1;
                    ctrl.del    = s1_reg;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            CMD_READ:
            begin
                if (pos_reg != '0 && pos_ext <= cnt_ext)
                begin
                    status_next = STAT_OK;
                    keep_next   = 1'b1;
                end
            end
            default:
            begin
                status_next = STAT_RANGE;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_W-1:0] prev_d;
            logic [DATA_W-1:0] next_d;
            if (i == 0)
            begin : g_first
                assign prev_d = value_reg;
            end
            else
            begin : g_mid_l
                assign prev_d = entry[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign next_d = entry[i];
            end
            else
            begin : g_mid_r
                assign next_d = entry[i+1];
            end
            pol_cell #(
                .INDEX(i)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .prev_data(prev_d),
                .next_data(next_d),
                .data     (entry[i]),
                .tap      (taps[i])
            );
        end
    endgenerate

    pol_gather #(
        .DEPTH(DEPTH)
    ) u_gather (
        .clk    (clk),
        .capture(s1_reg),
        .taps   (taps),
        .result (gathered)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= 1'b0;
            s2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            s1_reg <= in_beat;
            s2_reg <= s1_reg;
            if (s1_reg)
            begin
                count_reg <= count_next;
            end
            if (s2_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            cmd_reg   <= s_tdata[1:0];
            pos_reg   <= s_tdata[9:2];
            value_reg <= s_tdata[41:10];
        end
        if (s1_reg)
        begin
            status_reg <= status_next;
            keep_reg   <= keep_next;
        end
        if (s2_reg)
        begin
            rdata_reg <= keep_reg ? gathered : '0;
            ecnt_reg  <= cnt_ext[ECNT_W-1:0];
            ostat_reg <= status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, ostat_reg, ecnt_reg, rdata_reg};

endmodule

>>> hw/rtl/pol_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_cell
// one list slot: holds its entry, takes the new value or a neighbor's entry on insert, a neighbor's on delete
// ----------------------------------------------------------------------------
module pol_cell #(
    parameter int INDEX = 0
) (
    input  logic                     clk,
    input  pol_pkg::cell_ctrl_t      ctrl,
    input  logic [pol_pkg::DATA_W-1:0] prev_data,
    input  logic [pol_pkg::DATA_W-1:0] next_data,
    output logic [pol_pkg::DATA_W-1:0] data,
    output logic [pol_pkg::DATA_W-1:0] tap
);
    import pol_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              hit;
    logic              after;

    assign hit   = (int'(ctrl.target) == INDEX);
    assign after = (int'(ctrl.target) < INDEX);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (hit)
            begin
                data_next = ctrl.value;
            end
            else if (after)
            begin
                data_next = prev_data;
            end
        end
        else if (ctrl.del && (hit || after))
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = hit ? data_reg : '0;

endmodule

>>> hw/rtl/pol_gather.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_gather
// registered or-tree that collects the one selected cell tap
// ----------------------------------------------------------------------------
module pol_gather #(
    parameter int DEPTH = pol_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       capture,
    input  logic [pol_pkg::DATA_W-1:0] taps [DEPTH],
    output logic [pol_pkg::DATA_W-1:0] result
);
    import pol_pkg::*;

    localparam int NG = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [DATA_W-1:0] group_reg  [NG];
    logic [DATA_W-1:0] group_next [NG];

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < DEPTH)
                begin
                    group_next[g] = group_next[g] | taps[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int g = 0; g < NG; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    always_comb
    begin
        result = '0;
        for (int g = 0; g < NG; g++)
        begin
            result = result | group_reg[g];
        end
    end

endmodule

>>> tb/tb_positional_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_ordered_list
// self-checking bench for the positional ordered list: a directed pass over
// empty, front, middle, tail, past-end and bad-command cases, then random
// traffic that fills the list to capacity and drains it again, with random
// gaps and back-pressure; a list mirror predicts every result beat in order
// ----------------------------------------------------------------------------
module tb_positional_ordered_list;

    import pol_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1100;
    localparam int QUIET_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_CAP   = 60;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [ECNT_W-1:0] count;
        logic [STAT_W-1:0] status;
    } list_reply_t;

    typedef enum int {GEN_GROW, GEN_SHRINK, GEN_MIXED} gen_mode_t;

    class list_tracker;
        logic [DATA_W-1:0] mirror[$];
        list_reply_t       expected_replies[$];
        int                errors;

        function int depth_used();
            return mirror.size();
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic [DATA_W-1:0] val);
            list_reply_t rep;
            int          fill;
            fill       = mirror.size();
            rep.value  = '0;
            rep.status = STAT_OK;
            if (cmd == CMD_INSERT)
            begin
                if (fill >= LIST_DEPTH)
                    rep.status = STAT_FULL;
                else if (pos < 1 || pos > fill + 1)
                    rep.status = STAT_RANGE;
                else
                    mirror.insert(pos - 1, val);
            end
            else if (cmd == CMD_DELETE || cmd == CMD_READ)
            begin
                if (pos < 1 || pos > fill)
                    rep.status = STAT_RANGE;
                else
                begin
                    rep.value = mirror[pos - 1];
                    if (cmd == CMD_DELETE)
                        mirror.delete(pos - 1);
                end
            end
            else
            begin
                rep.status = STAT_RANGE;
            end
            rep.count = ECNT_W'(mirror.size());
            expected_replies.push_back(rep);
        endfunction

        function void report(string field, logic [DATA_W-1:0] exp_v,
                             logic [DATA_W-1:0] act_v);
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t mismatch %s: expected %h actual %h", $time, field, exp_v, act_v);
        endfunction

        function void check_response(logic [M_TDATA_W-1:0] beat);
            list_reply_t exp_r;
            if (expected_replies.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result beat: expected none actual %h", $time, beat);
                return;
            end
            exp_r = expected_replies.pop_front();
            if (beat[31:0] !== exp_r.value)
                report("read_value", exp_r.value, beat[31:0]);
            if (beat[39:32] !== exp_r.count)
                report("entry_count", DATA_W'(exp_r.count), DATA_W'(beat[39:32]));
            if (beat[41:40] !== exp_r.status)
                report("status", DATA_W'(exp_r.status), DATA_W'(beat[41:40]));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    list_tracker book;
    bit          idle_on;
    int          cycles;

    positional_ordered_list #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            book.check_response(m_tdata);
    end

    // result side back-pressure
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] val);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(S_TDATA_W - DATA_W - POS_W - CMD_W){1'b0}}, val, pos, cmd};
        do @(posedge clk); while (!s_tready);
        book.note_request(cmd, pos, val);
    endtask

    task automatic drain_list_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (book.pending() != 0) @(negedge clk);
    endtask

    task automatic send_random(input gen_mode_t gm);
        int                fill;
        int                r;
        int                pos;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] val;
        fill = book.depth_used();
        r    = $urandom_range(0, 99);
        case (gm)
            GEN_GROW:
                cmd = (r < 75) ? CMD_INSERT : (r < 85) ? CMD_DELETE :
                      (r < 98) ? CMD_READ : CMD_UNUSED;
            GEN_SHRINK:
                cmd = (r < 10) ? CMD_INSERT : (r < 80) ? CMD_DELETE :
                      (r < 98) ? CMD_READ : CMD_UNUSED;
            default:
                cmd = (r < 35) ? CMD_INSERT : (r < 65) ? CMD_DELETE :
                      (r < 98) ? CMD_READ : CMD_UNUSED;
        endcase
        r = $urandom_range(0, 99);
        if (r < 80)
            pos = (cmd == CMD_INSERT) ? $urandom_range(1, fill + 1)
                                      : $urandom_range(1, (fill == 0) ? 1 : fill);
        else if (r < 90)
        begin
            case ($urandom_range(0, 3))
                0:       pos = 0;
                1:       pos = fill;
                2:       pos = fill + 1;
                default: pos = fill + 2;
            endcase
        end
        else
            pos = $urandom_range(0, 255);
        case ($urandom_range(0, 15))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7fff_ffff;
            2:       val = 32'h0000_0000;
            3:       val = 32'hffff_ffff;
            default: val = $urandom;
        endcase
        send_beat(cmd, pos[POS_W-1:0], val);
    endtask

    initial
    begin
        gen_mode_t gm;
        int        seg_left;
        int        full_run;
        int        n;

        book     = new();
        idle_on  = 1'b1;
        cycles   = 0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // empty list, bad positions, then front/middle/tail traffic
        send_beat(CMD_READ,   8'd1,   32'h0000_0000);
        send_beat(CMD_DELETE, 8'd1,   32'h0000_0000);
        send_beat(CMD_INSERT, 8'd0,   32'h1111_1111);
        send_beat(CMD_INSERT, 8'd2,   32'h2222_2222);
        send_beat(CMD_INSERT, 8'd1,   32'h8000_0000);
        send_beat(CMD_INSERT, 8'd2,   32'h7fff_ffff);
        send_beat(CMD_INSERT, 8'd1,   32'hffff_ffff);
        send_beat(CMD_INSERT, 8'd4,   32'h0000_0000);
        send_beat(CMD_INSERT, 8'd2,   32'h1234_5678);
        send_beat(CMD_READ,   8'd1,   32'hffff_ffff);
        send_beat(CMD_READ,   8'd5,   32'h0000_0000);
        send_beat(CMD_READ,   8'd6,   32'h0000_0000);
        send_beat(CMD_READ,   8'd0,   32'h0000_0000);
        send_beat(CMD_READ,   8'd255, 32'h0000_0000);
        send_beat(CMD_INSERT, 8'd255, 32'haaaa_5555);
        send_beat(CMD_UNUSED, 8'd1,   32'h5555_aaaa);
        send_beat(CMD_DELETE, 8'd3,   32'h0000_0000);
        send_beat(CMD_DELETE, 8'd1,   32'h0000_0000);
        send_beat(CMD_DELETE, 8'd3,   32'h0000_0000);
        send_beat(CMD_DELETE, 8'd3,   32'h0000_0000);
        send_beat(CMD_READ,   8'd2,   32'h0000_0000);
        drain_list_results();

        gm       = GEN_GROW;
        seg_left = 0;
        full_run = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            if (n == RANDOM_ITEMS / 2)
                drain_list_results();
            case (gm)
                GEN_GROW:
                    if (book.depth_used() == LIST_DEPTH)
                    begin
                        full_run++;
                        if (full_run > 12)
                        begin
                            gm       = GEN_SHRINK;
                            full_run = 0;
                        end
                    end
                GEN_SHRINK:
                    if (book.depth_used() == 0)
                    begin
                        gm       = GEN_MIXED;
                        seg_left = $urandom_range(80, 200);
                    end
                default:
                begin
                    seg_left--;
                    if (seg_left <= 0)
                        gm = GEN_GROW;
                end
            endcase
            send_random(gm);
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (book.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (book.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
